FILE: rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants of the swap slot allocator
// Geometry of the slot bitmap, result codes and controller types.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int SLOT_COUNT       = 1024;
    localparam int SECTORS_PER_SLOT = 8;

    localparam int SLOT_IDX_W = 10;
    localparam int SECTOR_W   = 13;
    localparam int STATUS_W   = 2;

    // Bitmap is kept as rows of ROW_BITS slots each
    localparam int ROW_BITS  = 32;
    localparam int BIT_W     = 5;
    localparam int ROW_COUNT = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int BEAT_W    = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;     // latch request, read its bitmap row
        logic commit;   // update the row, set up the result run
        logic emit;     // drive one result beat
    } t_ctrl_cmd;

    typedef struct packed {
        logic done;     // current beat is the final one
    } t_dp_status;

    // Bits of a row that lie beyond the last slot read as used
    function automatic logic [ROW_BITS-1:0] row_pad(input logic [ROW_W-1:0] row);
        logic [ROW_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            m[b] = ((int'(row) * ROW_BITS + b) >= SLOT_COUNT);
        end
        return m;
    endfunction

endpackage

FILE: rtl/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl: request sequencer
// Steps each request through row lookup and the run of result beats.
// ----------------------------------------------------------------------------
module ssa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ssa_pkg::t_dp_status i_status,
    output logic                o_busy,
    output ssa_pkg::t_ctrl_cmd  o_cmd
);

    ssa_pkg::t_state r_state;
    ssa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssa_pkg::S_IDLE: begin
                if (i_start) n_state = ssa_pkg::S_LOOKUP;
            end
            ssa_pkg::S_LOOKUP: begin
                n_state = ssa_pkg::S_EMIT;
            end
            ssa_pkg::S_EMIT: begin
                if (i_status.done) n_state = ssa_pkg::S_IDLE;
            end
            default: begin
                n_state = ssa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy        = 1'b1;
        o_cmd         = '0;
        case (r_state)
            ssa_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ssa_pkg::S_LOOKUP: begin
                o_cmd.commit = 1'b1;
            end
            ssa_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/ssa_datapath.sv
// ----------------------------------------------------------------------------
// ssa_datapath: slot bitmap and result generation
// Row memory with per-row valid and full flags, first-fit search, release
// check and the sector address counter behind the result register.
// ----------------------------------------------------------------------------
module ssa_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssa_pkg::t_ctrl_cmd                  i_cmd,
    input  logic                                i_func,
    input  logic [ssa_pkg::SLOT_IDX_W-1:0]      i_slot_to_release,
    output ssa_pkg::t_dp_status                 o_status,
    output logic                                o_strobe,
    output logic [ssa_pkg::SLOT_IDX_W-1:0]      o_slot_index,
    output logic [ssa_pkg::SECTOR_W-1:0]        o_sector_address,
    output logic                                o_is_write,
    output logic [ssa_pkg::STATUS_W-1:0]        o_status_code,
    output logic                                o_last
);

    localparam int RB = ssa_pkg::ROW_BITS;
    localparam int RC = ssa_pkg::ROW_COUNT;
    localparam int RW = ssa_pkg::ROW_W;
    localparam int BW = ssa_pkg::BIT_W;

    logic [RB-1:0] mem [RC];

    logic [RC-1:0] r_row_valid;
    logic [RC-1:0] r_row_full;
    logic [RB-1:0] r_rd_data;

    logic                           r_func;
    logic [ssa_pkg::SLOT_IDX_W-1:0] r_req;
    logic [RW-1:0]                  r_row;
    logic                           r_any_free;
    logic                           r_in_range;

    logic [ssa_pkg::SLOT_IDX_W-1:0] r_slot;
    logic [ssa_pkg::SECTOR_W-1:0]   r_addr;
    logic [ssa_pkg::BEAT_W-1:0]     r_beat;
    logic                           r_is_write;
    ssa_pkg::t_status               r_code;
    logic                           r_err;

    logic                           r_o_valid;
    logic [ssa_pkg::SLOT_IDX_W-1:0] r_o_slot;
    logic [ssa_pkg::SECTOR_W-1:0]   r_o_sector;
    logic                           r_o_wr;
    ssa_pkg::t_status               r_o_code;
    logic                           r_o_last;

    // Accept-cycle row selection
    logic [31:0]   req_ext;
    logic [RW-1:0] req_row;
    logic          req_in_range;
    logic [RW-1:0] free_row;
    logic [RW-1:0] sel_row;

    always_comb begin
        req_ext      = 32'(i_slot_to_release);
        req_in_range = (req_ext < 32'(ssa_pkg::SLOT_COUNT));
        req_row      = req_in_range ? RW'(req_ext >> BW) : '0;
        free_row     = '0;
        for (int i = RC - 1; i >= 0; i--) begin
            if (!r_row_full[i]) free_row = RW'(i);
        end
        sel_row = (i_func == ssa_pkg::FUNC_ALLOC) ? free_row : req_row;
    end

    // Lookup-cycle row update
    logic [RB-1:0]   word;
    logic [RB-1:0]   pad;
    logic [RB-1:0]   avail;
    logic [BW-1:0]   first_free;
    logic [BW-1:0]   req_bit;
    logic [RB-1:0]   new_word;
    logic            err;
    logic [31:0]     slot_ext;
    logic            is_alloc;

    always_comb begin
        is_alloc   = (r_func == ssa_pkg::FUNC_ALLOC);
        word       = r_row_valid[r_row] ? r_rd_data : '0;
        pad        = ssa_pkg::row_pad(r_row);
        avail      = ~(word | pad);
        first_free = '0;
        for (int b = RB - 1; b >= 0; b--) begin
            if (avail[b]) first_free = BW'(b);
        end
        req_bit = r_req[BW-1:0];
        if (is_alloc) begin
            err      = !r_any_free;
            new_word = word | (RB'(1) << first_free);
            slot_ext = (32'(r_row) << BW) | 32'(first_free);
        end else begin
            err      = !r_in_range || !word[req_bit];
            new_word = word & ~(RB'(1) << req_bit);
            slot_ext = 32'(r_req);
        end
    end

    assign o_status.done = r_err || (r_beat == ssa_pkg::BEAT_W'(ssa_pkg::SECTORS_PER_SLOT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= mem[sel_row];
        end
        if (i_cmd.commit && !err) begin
            mem[r_row] <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_row_full  <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
            if (i_cmd.commit && !err) begin
                r_row_valid[r_row] <= 1'b1;
                r_row_full[r_row]  <= &(new_word | pad);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_req      <= i_slot_to_release;
            r_row      <= sel_row;
            r_any_free <= ~&r_row_full;
            r_in_range <= req_in_range;
        end
        if (i_cmd.commit) begin
            r_beat     <= '0;
            r_err      <= err;
            r_is_write <= is_alloc;
            if (err) begin
                r_addr <= '0;
                r_slot <= is_alloc ? '0 : r_req;
                r_code <= is_alloc ? ssa_pkg::ST_FULL : ssa_pkg::ST_NOT_USED;
            end else begin
                r_addr <= ssa_pkg::SECTOR_W'(slot_ext * 32'(ssa_pkg::SECTORS_PER_SLOT));
                r_slot <= ssa_pkg::SLOT_IDX_W'(slot_ext);
                r_code <= ssa_pkg::ST_OK;
            end
        end
        if (i_cmd.emit) begin
            r_o_slot   <= r_slot;
            r_o_sector <= r_addr;
            r_o_wr     <= r_is_write;
            r_o_code   <= r_code;
            r_o_last   <= o_status.done;
            // advance to the next sector of the page
            r_addr     <= r_addr + 1'b1;
            r_beat     <= r_beat + 1'b1;
        end
    end

    assign o_strobe         = r_o_valid;
    assign o_slot_index     = r_o_slot;
    assign o_sector_address = r_o_sector;
    assign o_is_write       = r_o_wr;
    assign o_status_code    = r_o_code;
    assign o_last           = r_o_last;

endmodule

FILE: rtl/swap_slot_allocator.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator: first-fit swap slot allocator with sector commands
// An ok request reads its bitmap row from the row memory, updates it,
// then gives one result beat per sector before the next request can be
// accepted. A failed request gives a single beat. Results leave through
// a register, in the cycle after they are formed, each valid for exactly
// the one cycle that o_strobe is high; the receiver cannot stall them
// and must take every beat. All slots are free after reset, with no
// clearing pass.
// ----------------------------------------------------------------------------
module swap_slot_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [ssa_pkg::SLOT_IDX_W-1:0]      i_slot_to_release,
    output logic                                o_strobe,
    output logic [ssa_pkg::SLOT_IDX_W-1:0]      o_slot_index,
    output logic [ssa_pkg::SECTOR_W-1:0]        o_sector_address,
    output logic                                o_is_write,
    output logic [ssa_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);

    ssa_pkg::t_ctrl_cmd  cmd;
    ssa_pkg::t_dp_status dp_status;

    ssa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    ssa_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_func            (i_func),
        .i_slot_to_release (i_slot_to_release),
        .o_status          (dp_status),
        .o_strobe          (o_strobe),
        .o_slot_index      (o_slot_index),
        .o_sector_address  (o_sector_address),
        .o_is_write        (o_is_write),
        .o_status_code     (o_status),
        .o_last            (o_last)
    );

endmodule

FILE: bench/swap_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// swap_slot_allocator_tb: self-checking bench of the swap slot allocator
// Walks a short directed table, then runs mixed random allocate and release
// requests under varying sender idling.
// Every result beat is checked field by field against a bitmap predictor.
// ----------------------------------------------------------------------------
module swap_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 35;

    typedef struct {
        logic [ssa_pkg::SLOT_IDX_W-1:0] slot;
        logic [ssa_pkg::SECTOR_W-1:0]   sector;
        logic                           is_write;
        ssa_pkg::t_status               status;
        logic                           last;
    } t_sector_beat;

    typedef struct {
        logic                           func;
        logic [ssa_pkg::SLOT_IDX_W-1:0] slot;
        bit                             typed;
        logic [ssa_pkg::SLOT_IDX_W-1:0] exp_slot;
        ssa_pkg::t_status               exp_status;
    } t_request_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_func;
    logic [ssa_pkg::SLOT_IDX_W-1:0] i_slot_to_release;
    logic                           o_strobe;
    logic [ssa_pkg::SLOT_IDX_W-1:0] o_slot_index;
    logic [ssa_pkg::SECTOR_W-1:0]   o_sector_address;
    logic                           o_is_write;
    logic [ssa_pkg::STATUS_W-1:0]   o_status;
    logic                           o_last;

    t_sector_beat pending_beats[$];
    t_request_row directed_rows[$];
    bit           slot_used[ssa_pkg::SLOT_COUNT];
    int           used_count;
    int           mismatches;
    int           cycle_count;
    int           send_idle_pct;

    swap_slot_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_slot_to_release (i_slot_to_release),
        .o_strobe          (o_strobe),
        .o_slot_index      (o_slot_index),
        .o_sector_address  (o_sector_address),
        .o_is_write        (o_is_write),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatches++;
    endtask

    // First-fit allocation or release on the shadow bitmap; returns the slot and status
    task automatic allocate_or_release(input logic func,
                                       input logic [ssa_pkg::SLOT_IDX_W-1:0] req,
                                       output logic [ssa_pkg::SLOT_IDX_W-1:0] slot,
                                       output ssa_pkg::t_status status);
        slot   = '0;
        status = ssa_pkg::ST_FULL;
        if (func == ssa_pkg::FUNC_ALLOC) begin
            for (int s = 0; s < ssa_pkg::SLOT_COUNT; s++) begin
                if (!slot_used[s]) begin
                    slot_used[s] = 1'b1;
                    used_count++;
                    slot   = s[ssa_pkg::SLOT_IDX_W-1:0];
                    status = ssa_pkg::ST_OK;
                    break;
                end
            end
        end else begin
            slot = req;
            if (int'(req) >= ssa_pkg::SLOT_COUNT || !slot_used[req]) begin
                status = ssa_pkg::ST_NOT_USED;
            end else begin
                slot_used[req] = 1'b0;
                used_count--;
                status = ssa_pkg::ST_OK;
            end
        end
    endtask

    // Expand one request outcome into its sector command beats
    task automatic queue_sector_beats(input logic [ssa_pkg::SLOT_IDX_W-1:0] slot,
                                      input logic is_write,
                                      input ssa_pkg::t_status status);
        t_sector_beat b;
        logic [31:0]  addr;
        b.slot     = slot;
        b.is_write = is_write;
        b.status   = status;
        if (status != ssa_pkg::ST_OK) begin
            b.sector = '0;
            b.last   = 1'b1;
            pending_beats.push_back(b);
        end else begin
            for (int k = 0; k < ssa_pkg::SECTORS_PER_SLOT; k++) begin
                addr     = int'(slot) * ssa_pkg::SECTORS_PER_SLOT + k;
                b.sector = addr[ssa_pkg::SECTOR_W-1:0];
                b.last   = (k == ssa_pkg::SECTORS_PER_SLOT - 1);
                pending_beats.push_back(b);
            end
        end
    endtask

    task automatic issue_request(input logic func, input logic [ssa_pkg::SLOT_IDX_W-1:0] req,
                                 input bit typed,
                                 input logic [ssa_pkg::SLOT_IDX_W-1:0] exp_slot,
                                 input ssa_pkg::t_status exp_status);
        logic [ssa_pkg::SLOT_IDX_W-1:0] slot;
        ssa_pkg::t_status               status;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_func            <= func;
        i_slot_to_release <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        allocate_or_release(func, req, slot, status);
        if (typed) begin
            queue_sector_beats(exp_slot, func == ssa_pkg::FUNC_ALLOC, exp_status);
        end else begin
            queue_sector_beats(slot, func == ssa_pkg::FUNC_ALLOC, status);
        end
    endtask

    task automatic predicted_request(input logic func,
                                     input logic [ssa_pkg::SLOT_IDX_W-1:0] req);
        issue_request(func, req, 1'b0, '0, ssa_pkg::ST_OK);
    endtask

    task automatic add_row(input logic func, input logic [ssa_pkg::SLOT_IDX_W-1:0] req,
                           input bit typed, input logic [ssa_pkg::SLOT_IDX_W-1:0] exp_slot,
                           input ssa_pkg::t_status exp_status);
        t_request_row r;
        r.func       = func;
        r.slot       = req;
        r.typed      = typed;
        r.exp_slot   = exp_slot;
        r.exp_status = exp_status;
        directed_rows.push_back(r);
    endtask

    function automatic logic [ssa_pkg::SLOT_IDX_W-1:0] pick_used_slot();
        int s;
        s = $urandom_range(ssa_pkg::SLOT_COUNT - 1);
        for (int n = 0; n < ssa_pkg::SLOT_COUNT; n++) begin
            if (slot_used[(s + n) % ssa_pkg::SLOT_COUNT])
                return ssa_pkg::SLOT_IDX_W'((s + n) % ssa_pkg::SLOT_COUNT);
        end
        return ssa_pkg::SLOT_IDX_W'(s);
    endfunction

    task automatic random_phase(input int idle_pct);
        logic func;
        send_idle_pct = idle_pct;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            func = 1'($urandom_range(1));
            // mostly release slots that are held, now and then a stray one
            if (func == ssa_pkg::FUNC_RELEASE && used_count > 0 &&
                $urandom_range(99) < 80) begin
                predicted_request(ssa_pkg::FUNC_RELEASE, pick_used_slot());
            end else begin
                predicted_request(func,
                    ssa_pkg::SLOT_IDX_W'($urandom_range(ssa_pkg::SLOT_COUNT - 1)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_sector_beat b;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("beat for slot %0d with nothing pending",
                                          o_slot_index));
            end else begin
                b = pending_beats.pop_front();
                if (o_slot_index !== b.slot)
                    report_mismatch($sformatf("slot_index got %0d expected %0d",
                                              o_slot_index, b.slot));
                if (o_sector_address !== b.sector)
                    report_mismatch($sformatf("sector_address got %0d expected %0d",
                                              o_sector_address, b.sector));
                if (o_is_write !== b.is_write)
                    report_mismatch($sformatf("is_write got %0b expected %0b",
                                              o_is_write, b.is_write));
                if (o_status !== b.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_status, b.status));
                if (o_last !== b.last)
                    report_mismatch($sformatf("last got %0b expected %0b", o_last, b.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0d] timeout, %0d beats outstanding", cycle_count, pending_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_func            <= ssa_pkg::FUNC_ALLOC;
        i_slot_to_release <= '0;
        used_count    = 0;
        mismatches    = 0;
        send_idle_pct = 31;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: releases of free slots after reset, first-fit reuse, extremes
        add_row(ssa_pkg::FUNC_RELEASE, 10'd0,    1'b1, 10'd0,    ssa_pkg::ST_NOT_USED);
        add_row(ssa_pkg::FUNC_RELEASE, 10'd1023, 1'b1, 10'd1023, ssa_pkg::ST_NOT_USED);
        add_row(ssa_pkg::FUNC_RELEASE, 10'h2AA,  1'b1, 10'h2AA,  ssa_pkg::ST_NOT_USED);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd0,    1'b1, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd0,    1'b1, 10'd1,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd0,    1'b1, 10'd2,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_ALLOC,   10'h155,  1'b0, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_RELEASE, 10'd1,    1'b1, 10'd1,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_RELEASE, 10'd1,    1'b1, 10'd1,    ssa_pkg::ST_NOT_USED);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd0,    1'b0, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd1023, 1'b0, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_RELEASE, 10'd3,    1'b0, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_RELEASE, 10'h155,  1'b1, 10'h155,  ssa_pkg::ST_NOT_USED);
        add_row(ssa_pkg::FUNC_RELEASE, 10'd0,    1'b1, 10'd0,    ssa_pkg::ST_OK);
        add_row(ssa_pkg::FUNC_ALLOC,   10'd0,    1'b0, 10'd0,    ssa_pkg::ST_OK);
        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].typed,
                          directed_rows[i].exp_slot, directed_rows[i].exp_status);
        end

        random_phase(31);
        random_phase(58);
        random_phase(0);
        start <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (ssa_pkg::SECTORS_PER_SLOT + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ssa_pkg.sv
rtl/ssa_ctrl.sv
rtl/ssa_datapath.sv
rtl/swap_slot_allocator.sv
bench/swap_slot_allocator_tb.sv
